// ===== hdl/qau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

    typedef logic [2:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_SUM = 3'd0;
    localparam t_op OP_DIF = 3'd1;
    localparam t_op OP_PRD = 3'd2;
    localparam t_op OP_QUO = 3'd3;
    localparam t_op OP_NEG = 3'd4;
    localparam t_op OP_CNJ = 3'd5;
    localparam t_op OP_INV = 3'd6;
    localparam t_op OP_DOT = 3'd7;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_DOMAIN   = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/qau_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface qau_req_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic [2:0]          req_type;
    logic signed [W-1:0] a_w;
    logic signed [W-1:0] a_x;
    logic signed [W-1:0] a_y;
    logic signed [W-1:0] a_z;
    logic signed [W-1:0] b_w;
    logic signed [W-1:0] b_x;
    logic signed [W-1:0] b_y;
    logic signed [W-1:0] b_z;

    modport source (
        output valid, req_type, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
        input  ready
    );
    modport sink (
        input  valid, req_type, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
        output ready
    );
endinterface

interface qau_rsp_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] r_w;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [W-1:0] r_z;
    logic [1:0]          status;

    modport source (
        output valid, r_w, r_x, r_y, r_z, status,
        input  ready
    );
    modport sink (
        input  valid, r_w, r_x, r_y, r_z, status,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/quaternion_arithmetic_unit_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Quaternion arithmetic unit, signed fixed-point components.
// i_req carries the opcode and quaternions a and b; o_rsp returns the
// result quaternion and a status (ok, divide by zero, saturated).
// Both channels use valid/ready; a transfer happens when both are high.
// Every opcode goes through the same pipeline of COMPONENT_WIDTH + 6
// register stages: operand setup, multiply, product sums, numerator
// forming, range check, one stage per quotient bit of the restoring
// divider, and the output register. One transfer is accepted per cycle
// unless the output stalls; the divider being fully unrolled into
// stages is what sets the latency.
// All stages advance together: while the output register holds a result
// that the receiver does not take, i_req.ready is low and the whole
// pipeline holds, so nothing is lost or repeated.
// Reset clears all stage valid bits; results in flight are dropped.

module quaternion_arithmetic_unit_core #(
    parameter int COMPONENT_WIDTH = 32,
    parameter int FRACTION_BITS   = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qau_req_if.sink    i_req,
    qau_rsp_if.source  o_rsp
);

    localparam int W   = COMPONENT_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int EW  = W + 1;
    localparam int PW  = 2 * EW;
    localparam int SW  = PW + 2;
    localparam int NQ  = SW + F;
    localparam int NI  = EW + 2 * F;
    localparam int NSW = (NQ > NI) ? NQ : NI;
    localparam int XW0 = (NSW > SW + W) ? NSW : SW + W;
    localparam int XW  = XW0 + 1;
    localparam int NS  = W + 6;

    typedef struct packed {
        logic         ovf;
        logic [W-1:0] val;
    } t_sat;

    typedef struct packed {
        logic [XW-1:0] rem;
        logic [W-1:0]  q;
        logic          neg;
        logic          big;
    } t_dcomp;

    function automatic logic signed [SW-1:0] ext_w(input logic [W-1:0] v);
        return {{(SW-W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [SW-1:0] ext_p(input logic [PW-1:0] v);
        return {{(SW-PW){v[PW-1]}}, v};
    endfunction

    function automatic t_sat sat(input logic [SW-1:0] v);
        t_sat         r;
        logic [SW-W:0] top;
        top   = v[SW-1:W-1];
        r.ovf = !((&top) || !(|top));
        r.val = r.ovf ? {v[SW-1], {(W-1){~v[SW-1]}}} : v[W-1:0];
        return r;
    endfunction

    logic            w_en;
    logic [NS-1:0]   r_v;

    logic [W-1:0]    w_a [4];
    logic [W-1:0]    w_b [4];

    // stage 1
    qau_pkg::t_op        r_s1_op;
    logic [W-1:0]        r_s1_a    [4];
    logic signed [EW-1:0] r_s1_ae  [4];
    logic signed [EW-1:0] r_s1_be  [4];
    logic signed [EW-1:0] r_s1_s   [4];
    logic [W-1:0]        r_s1_dres [4];
    logic                r_s1_dov;
    logic signed [EW-1:0] n_s1_ae  [4];
    logic signed [EW-1:0] n_s1_be  [4];
    logic signed [EW-1:0] n_s1_s   [4];
    logic [W-1:0]        n_s1_dres [4];
    logic                n_s1_dov;

    // stage 2
    qau_pkg::t_op        r_s2_op;
    logic [W-1:0]        r_s2_a    [4];
    logic signed [PW-1:0] r_s2_p   [4][4];
    logic signed [PW-1:0] r_s2_sq  [4];
    logic [W-1:0]        r_s2_dres [4];
    logic                r_s2_dov;

    // stage 3
    qau_pkg::t_op        r_s3_op;
    logic [W-1:0]        r_s3_a    [4];
    logic signed [SW-1:0] r_s3_h   [4];
    logic signed [SW-1:0] r_s3_dot;
    logic [SW-1:0]       r_s3_den;
    logic [W-1:0]        r_s3_dres [4];
    logic                r_s3_dov;
    logic signed [SW-1:0] n_s3_h   [4];
    logic signed [SW-1:0] n_s3_dot;
    logic [SW-1:0]       n_s3_den;

    // stage 4
    logic [NSW-1:0]      r_s4_mag  [4];
    logic                r_s4_neg  [4];
    logic [SW-1:0]       r_s4_den;
    logic                r_s4_div;
    logic                r_s4_dz;
    logic [W-1:0]        r_s4_dres [4];
    logic                r_s4_dov;
    logic [NSW-1:0]      n_s4_mag  [4];
    logic                n_s4_neg  [4];
    logic [W-1:0]        n_s4_dres [4];
    logic                n_s4_dov;

    // divider stages
    t_dcomp              r_dc    [W+1][4];
    logic [SW-1:0]       r_dden  [W+1];
    logic                r_ddiv  [W+1];
    logic                r_ddz   [W+1];
    logic [W-1:0]        r_ddres [W+1][4];
    logic                r_ddov  [W+1];
    t_dcomp              n_dc    [W+1][4];

    // output
    logic [W-1:0]        r_o_res [4];
    qau_pkg::t_status    r_o_st;
    logic [W-1:0]        n_o_res [4];
    qau_pkg::t_status    n_o_st;

    assign w_en        = !r_v[NS-1] || o_rsp.ready;
    assign i_req.ready = w_en;

    assign w_a[0] = i_req.a_w;
    assign w_a[1] = i_req.a_x;
    assign w_a[2] = i_req.a_y;
    assign w_a[3] = i_req.a_z;
    assign w_b[0] = i_req.b_w;
    assign w_b[1] = i_req.b_x;
    assign w_b[2] = i_req.b_y;
    assign w_b[3] = i_req.b_z;

    // operand setup and the add-type opcodes
    always_comb begin
        logic signed [EW-1:0] ea;
        logic signed [EW-1:0] eb;
        logic signed [SW-1:0] t;
        t_sat                 s;
        n_s1_dov = 1'b0;
        for (int i = 0; i < 4; i++) begin
            ea = {w_a[i][W-1], w_a[i]};
            eb = {w_b[i][W-1], w_b[i]};
            n_s1_ae[i] = ea;
            // quotient multiplies by conj(b)
            n_s1_be[i] = (i_req.req_type == qau_pkg::OP_QUO && i != 0) ? -eb : eb;
            n_s1_s[i]  = (i_req.req_type == qau_pkg::OP_INV) ? ea : eb;
            case (i_req.req_type)
                qau_pkg::OP_SUM: t = ext_w(w_a[i]) + ext_w(w_b[i]);
                qau_pkg::OP_DIF: t = ext_w(w_a[i]) - ext_w(w_b[i]);
                qau_pkg::OP_NEG: t = -ext_w(w_a[i]);
                qau_pkg::OP_CNJ: t = (i == 0) ? ext_w(w_a[i]) : -ext_w(w_a[i]);
                default:         t = '0;
            endcase
            s            = sat(t);
            n_s1_dres[i] = s.val;
            n_s1_dov     = n_s1_dov | s.ovf;
        end
    end

    // hamilton product sums, dot product and squared norm
    always_comb begin
        n_s3_h[0] = ext_p(r_s2_p[0][0]) - ext_p(r_s2_p[1][1])
                  - ext_p(r_s2_p[2][2]) - ext_p(r_s2_p[3][3]);
        n_s3_h[1] = ext_p(r_s2_p[0][1]) + ext_p(r_s2_p[1][0])
                  + ext_p(r_s2_p[2][3]) - ext_p(r_s2_p[3][2]);
        n_s3_h[2] = ext_p(r_s2_p[0][2]) + ext_p(r_s2_p[2][0])
                  + ext_p(r_s2_p[3][1]) - ext_p(r_s2_p[1][3]);
        n_s3_h[3] = ext_p(r_s2_p[0][3]) + ext_p(r_s2_p[3][0])
                  + ext_p(r_s2_p[1][2]) - ext_p(r_s2_p[2][1]);
        n_s3_dot  = ext_p(r_s2_p[0][0]) + ext_p(r_s2_p[1][1])
                  + ext_p(r_s2_p[2][2]) + ext_p(r_s2_p[3][3]);
        n_s3_den  = ext_p(r_s2_sq[0]) + ext_p(r_s2_sq[1])
                  + ext_p(r_s2_sq[2]) + ext_p(r_s2_sq[3]);
    end

    // rescale product/dot, form divider numerators
    always_comb begin
        logic signed [SW-1:0]  hs;
        logic signed [EW-1:0]  ci;
        logic [NSW-1:0]        numq;
        logic [NSW-1:0]        numi;
        logic [NSW-1:0]        num;
        t_sat                  s;
        n_s4_dov = r_s3_dov;
        for (int c = 0; c < 4; c++) begin
            n_s4_dres[c] = r_s3_dres[c];
        end
        case (r_s3_op)
            qau_pkg::OP_PRD: begin
                n_s4_dov = 1'b0;
                for (int c = 0; c < 4; c++) begin
                    hs           = r_s3_h[c] >>> F;
                    s            = sat(hs);
                    n_s4_dres[c] = s.val;
                    n_s4_dov     = n_s4_dov | s.ovf;
                end
            end
            qau_pkg::OP_DOT: begin
                hs           = r_s3_dot >>> F;
                s            = sat(hs);
                n_s4_dres[0] = s.val;
                n_s4_dres[1] = '0;
                n_s4_dres[2] = '0;
                n_s4_dres[3] = '0;
                n_s4_dov     = s.ovf;
            end
            default: begin
            end
        endcase
        for (int c = 0; c < 4; c++) begin
            numq = {{(NSW-SW){r_s3_h[c][SW-1]}}, r_s3_h[c]} << F;
            ci   = (c == 0) ? {r_s3_a[c][W-1], r_s3_a[c]}
                            : -{r_s3_a[c][W-1], r_s3_a[c]};
            numi = {{(NSW-EW){ci[EW-1]}}, ci} << (2 * F);
            num  = (r_s3_op == qau_pkg::OP_INV) ? numi : numq;
            n_s4_neg[c] = num[NSW-1];
            n_s4_mag[c] = num[NSW-1] ? -num : num;
        end
    end

    // range check, then one restoring step per quotient bit
    always_comb begin
        logic [XW-1:0] dsh;
        logic [XW-1:0] mx;
        dsh = {{(XW-SW){1'b0}}, r_s4_den} << W;
        for (int c = 0; c < 4; c++) begin
            mx              = {{(XW-NSW){1'b0}}, r_s4_mag[c]};
            n_dc[0][c].rem  = mx;
            n_dc[0][c].q    = '0;
            n_dc[0][c].neg  = r_s4_neg[c];
            n_dc[0][c].big  = (mx >= dsh);
        end
        for (int k = 0; k < W; k++) begin
            dsh = {{(XW-SW){1'b0}}, r_dden[k]} << (W - 1 - k);
            for (int c = 0; c < 4; c++) begin
                n_dc[k+1][c] = r_dc[k][c];
                if (r_dc[k][c].rem >= dsh) begin
                    n_dc[k+1][c].rem         = r_dc[k][c].rem - dsh;
                    n_dc[k+1][c].q[W-1-k]    = 1'b1;
                end
            end
        end
    end

    // sign, saturation and status
    always_comb begin
        logic [W:0] qv;
        logic [W:0] sv;
        logic       ovf;
        logic       any;
        any = 1'b0;
        for (int c = 0; c < 4; c++) begin
            qv  = {1'b0, r_dc[W][c].q};
            sv  = r_dc[W][c].neg ? -qv : qv;
            ovf = r_dc[W][c].big || (sv[W] != sv[W-1]);
            any = any | ovf;
            if (!r_ddiv[W]) begin
                n_o_res[c] = r_ddres[W][c];
            end else if (r_ddz[W]) begin
                n_o_res[c] = '0;
            end else if (ovf) begin
                n_o_res[c] = {r_dc[W][c].neg, {(W-1){~r_dc[W][c].neg}}};
            end else begin
                n_o_res[c] = sv[W-1:0];
            end
        end
        if (!r_ddiv[W]) begin
            n_o_st = r_ddov[W] ? qau_pkg::ST_OVERFLOW : qau_pkg::ST_OK;
        end else if (r_ddz[W]) begin
            n_o_st = qau_pkg::ST_DOMAIN;
        end else begin
            n_o_st = any ? qau_pkg::ST_OVERFLOW : qau_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NS-2:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_op  <= i_req.req_type;
            r_s1_dov <= n_s1_dov;
            r_s2_op  <= r_s1_op;
            r_s2_dov <= r_s1_dov;
            r_s3_op  <= r_s2_op;
            r_s3_dov <= r_s2_dov;
            r_s3_dot <= n_s3_dot;
            r_s3_den <= n_s3_den;
            r_s4_den <= r_s3_den;
            r_s4_div <= (r_s3_op == qau_pkg::OP_QUO) || (r_s3_op == qau_pkg::OP_INV);
            r_s4_dz  <= (r_s3_den == '0);
            r_s4_dov <= n_s4_dov;
            r_dden[0] <= r_s4_den;
            r_ddiv[0] <= r_s4_div;
            r_ddz[0]  <= r_s4_dz;
            r_ddov[0] <= r_s4_dov;
            for (int i = 0; i < 4; i++) begin
                r_s1_a[i]    <= w_a[i];
                r_s1_ae[i]   <= n_s1_ae[i];
                r_s1_be[i]   <= n_s1_be[i];
                r_s1_s[i]    <= n_s1_s[i];
                r_s1_dres[i] <= n_s1_dres[i];
                r_s2_a[i]    <= r_s1_a[i];
                r_s2_sq[i]   <= r_s1_s[i] * r_s1_s[i];
                r_s2_dres[i] <= r_s1_dres[i];
                for (int j = 0; j < 4; j++) begin
                    r_s2_p[i][j] <= r_s1_ae[i] * r_s1_be[j];
                end
                r_s3_a[i]    <= r_s2_a[i];
                r_s3_h[i]    <= n_s3_h[i];
                r_s3_dres[i] <= r_s2_dres[i];
                r_s4_mag[i]  <= n_s4_mag[i];
                r_s4_neg[i]  <= n_s4_neg[i];
                r_s4_dres[i] <= n_s4_dres[i];
                r_ddres[0][i] <= r_s4_dres[i];
                r_o_res[i]   <= n_o_res[i];
            end
            for (int k = 0; k <= W; k++) begin
                for (int c = 0; c < 4; c++) begin
                    r_dc[k][c] <= n_dc[k][c];
                end
            end
            for (int k = 1; k <= W; k++) begin
                r_dden[k] <= r_dden[k-1];
                r_ddiv[k] <= r_ddiv[k-1];
                r_ddz[k]  <= r_ddz[k-1];
                r_ddov[k] <= r_ddov[k-1];
                for (int c = 0; c < 4; c++) begin
                    r_ddres[k][c] <= r_ddres[k-1][c];
                end
            end
            r_o_st <= n_o_st;
        end
    end

    assign o_rsp.valid  = r_v[NS-1];
    assign o_rsp.r_w    = r_o_res[0];
    assign o_rsp.r_x    = r_o_res[1];
    assign o_rsp.r_y    = r_o_res[2];
    assign o_rsp.r_z    = r_o_res[3];
    assign o_rsp.status = r_o_st;

endmodule

`default_nettype wire

// ===== hdl/qau_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qau_checker #(
    parameter int W = 32
) (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_in_ready,
    input wire logic         i_out_valid,
    input wire logic         i_out_ready,
    input wire logic [W-1:0] i_r_w,
    input wire logic [W-1:0] i_r_x,
    input wire logic [W-1:0] i_r_y,
    input wire logic [W-1:0] i_r_z,
    input wire logic [1:0]   i_status
);

    // a stalled result holds its status and its w and x components
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_r_w) && $stable(i_r_x))
        else $error("stalled result changed");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status != 2'd3)
        else $error("undefined status code");

    // divide by zero always returns a zero quaternion
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == qau_pkg::ST_DOMAIN |->
            i_r_w == '0 && i_r_x == '0 && i_r_y == '0 && i_r_z == '0)
        else $error("domain status with nonzero result");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("transfer taken while pipeline stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind quaternion_arithmetic_unit_core qau_checker #(.W(COMPONENT_WIDTH)) u_qau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_r_w       (o_rsp.r_w),
    .i_r_x       (o_rsp.r_x),
    .i_r_y       (o_rsp.r_y),
    .i_r_z       (o_rsp.r_z),
    .i_status    (o_rsp.status)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE   = 1 <<< FB;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        qau_pkg::t_op         op;
        logic signed [CW-1:0] a[4];
        logic signed [CW-1:0] b[4];
    } t_quat_req;

    typedef struct {
        logic signed [CW-1:0] r[4];
        qau_pkg::t_status     st;
    } t_quat_rsp;

    logic i_clk;
    logic i_rst_n;
    qau_req_if #(.W(CW)) req_if ();
    qau_rsp_if #(.W(CW)) rsp_if ();

    quaternion_arithmetic_unit_core #(
        .COMPONENT_WIDTH(CW),
        .FRACTION_BITS  (FB)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    t_quat_rsp pending_results[$];
    int        errors = 0;
    bit        idling_on = 1;
    int        rx_hold_cycles = 0;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4ms;
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------- prediction
    function automatic void hamilton_exact(input t_wide p[4], input t_wide q[4],
                                           output t_wide r[4]);
        r[0] = p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3];
        r[1] = p[0]*q[1] + p[1]*q[0] + p[2]*q[3] - p[3]*q[2];
        r[2] = p[0]*q[2] + p[2]*q[0] + p[3]*q[1] - p[1]*q[3];
        r[3] = p[0]*q[3] + p[3]*q[0] + p[1]*q[2] - p[2]*q[1];
    endfunction

    function automatic t_quat_rsp quat_result(input t_quat_req it);
        t_wide     a[4], b[4], t[4], r[4];
        t_wide     den;
        bit        dom, ovf;
        t_quat_rsp res;
        dom = 0;
        ovf = 0;
        for (int i = 0; i < 4; i++) begin
            a[i] = it.a[i];
            b[i] = it.b[i];
            r[i] = 0;
        end
        case (it.op)
            qau_pkg::OP_SUM: for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
            qau_pkg::OP_DIF: for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
            qau_pkg::OP_PRD: begin
                hamilton_exact(a, b, r);
                for (int i = 0; i < 4; i++) r[i] = r[i] >>> FB;
            end
            qau_pkg::OP_QUO: begin
                den = b[0]*b[0] + b[1]*b[1] + b[2]*b[2] + b[3]*b[3];
                if (den == 0) begin
                    dom = 1;
                end else begin
                    t[0] = b[0];
                    for (int i = 1; i < 4; i++) t[i] = -b[i];
                    hamilton_exact(a, t, r);
                    for (int i = 0; i < 4; i++) r[i] = (r[i] <<< FB) / den;
                end
            end
            qau_pkg::OP_NEG: for (int i = 0; i < 4; i++) r[i] = -a[i];
            qau_pkg::OP_CNJ: begin
                r[0] = a[0];
                for (int i = 1; i < 4; i++) r[i] = -a[i];
            end
            qau_pkg::OP_INV: begin
                den = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
                if (den == 0) begin
                    dom = 1;
                end else begin
                    for (int i = 0; i < 4; i++)
                        r[i] = (((i == 0) ? a[0] : -a[i]) <<< (2*FB)) / den;
                end
            end
            default: begin
                r[0] = (a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3]) >>> FB;
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            if (dom) begin
                res.r[i] = 0;
            end else if (r[i] > t_wide'(C_MAX)) begin
                res.r[i] = C_MAX;
                ovf = 1;
            end else if (r[i] < t_wide'(C_MIN)) begin
                res.r[i] = C_MIN;
                ovf = 1;
            end else begin
                res.r[i] = r[i][CW-1:0];
            end
        end
        res.st = dom ? qau_pkg::ST_DOMAIN : (ovf ? qau_pkg::ST_OVERFLOW : qau_pkg::ST_OK);
        return res;
    endfunction

    // ---------------------------------------------------------------- monitors
    always @(posedge i_clk) begin
        t_quat_req it;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            it.op = qau_pkg::t_op'(req_if.req_type);
            it.a  = '{req_if.a_w, req_if.a_x, req_if.a_y, req_if.a_z};
            it.b  = '{req_if.b_w, req_if.b_x, req_if.b_y, req_if.b_z};
            pending_results.push_back(quat_result(it));
        end
    end

    always @(posedge i_clk) begin
        t_quat_rsp exp_r;
        logic signed [CW-1:0] got[4];
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                got = '{rsp_if.r_w, rsp_if.r_x, rsp_if.r_y, rsp_if.r_z};
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== exp_r.r[i]) begin
                        $error("r_%s expected %h actual %h",
                               (i == 0) ? "w" : (i == 1) ? "x" : (i == 2) ? "y" : "z",
                               exp_r.r[i], got[i]);
                        errors++;
                    end
                end
                if (rsp_if.status !== exp_r.st) begin
                    $error("status expected %0d actual %0d", exp_r.st, rsp_if.status);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_if.ready = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rsp_if.ready = 0;
                rx_hold_cycles--;
            end else if (stall_left > 0) begin
                rsp_if.ready = 0;
                stall_left--;
            end else begin
                rsp_if.ready = 1;
                if (idling_on && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 18);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_quat(input t_quat_req it);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            req_if.valid = 0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        req_if.req_type = it.op;
        {req_if.a_w, req_if.a_x, req_if.a_y, req_if.a_z} = {it.a[0], it.a[1], it.a[2], it.a[3]};
        {req_if.b_w, req_if.b_x, req_if.b_y, req_if.b_z} = {it.b[0], it.b[1], it.b[2], it.b[3]};
        req_if.valid = 1;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_ops(input qau_pkg::t_op op,
                            input logic signed [CW-1:0] aw, ax, ay, az,
                            input logic signed [CW-1:0] bw, bx, by, bz);
        t_quat_req it;
        it.op = op;
        it.a  = '{aw, ax, ay, az};
        it.b  = '{bw, bx, by, bz};
        send_quat(it);
    endtask

    function automatic logic signed [CW-1:0] rand_component();
        case ($urandom_range(0, 9))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return 0;
            3, 4, 5: return $urandom;
            default: return $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic t_quat_req rand_quat();
        t_quat_req it;
        it.op = qau_pkg::t_op'($urandom_range(0, 7));
        for (int i = 0; i < 4; i++) begin
            it.a[i] = rand_component();
            it.b[i] = rand_component();
        end
        // zero divisors now and then
        if ($urandom_range(0, 11) == 0) it.b = '{0, 0, 0, 0};
        if ($urandom_range(0, 11) == 0) it.a = '{0, 0, 0, 0};
        return it;
    endfunction

    task automatic wait_drained();
        req_if.valid = 0;
        wait (pending_results.size() == 0);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_ops(qau_pkg::OP_SUM, C_MAX, C_MIN, 1, -1, C_MAX, C_MIN, -1, 1);
        send_ops(qau_pkg::OP_SUM, 1, 2, 3, 4, 5, 6, 7, 8);
        send_ops(qau_pkg::OP_DIF, C_MIN, C_MAX, 0, -5, C_MAX, C_MIN, C_MIN, 7);
        send_ops(qau_pkg::OP_PRD, 0, ONE, 0, 0, 0, 0, ONE, 0);
        send_ops(qau_pkg::OP_PRD, -3, 5, -7, 1, 1, -1, 3, -9);
        send_ops(qau_pkg::OP_PRD, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN);
        send_ops(qau_pkg::OP_QUO, ONE, 2*ONE, -ONE, 3, 2*ONE, 0, ONE, -ONE);
        send_ops(qau_pkg::OP_QUO, ONE, ONE, ONE, ONE, 0, 0, 0, 0);
        send_ops(qau_pkg::OP_QUO, C_MAX, C_MIN, C_MAX, C_MIN, 0, 1, 0, 0);
        send_ops(qau_pkg::OP_QUO, -7, 3, 0, 0, 0, 0, 0, C_MIN);
        send_ops(qau_pkg::OP_NEG, C_MIN, C_MAX, 0, -1, 0, 0, 0, 0);
        send_ops(qau_pkg::OP_NEG, 5, -5, ONE, 1, C_MIN, C_MIN, C_MIN, C_MIN);
        send_ops(qau_pkg::OP_CNJ, C_MIN, C_MIN, C_MAX, 1, 0, 0, 0, 0);
        send_ops(qau_pkg::OP_CNJ, -ONE, 3, -4, 0, 9, 9, 9, 9);
        send_ops(qau_pkg::OP_INV, 0, 0, 0, 0, ONE, ONE, ONE, ONE);
        send_ops(qau_pkg::OP_INV, 2*ONE, 0, 0, 0, 0, 0, 0, 0);
        send_ops(qau_pkg::OP_INV, 1, 0, 0, -1, 0, 0, 0, 0);
        send_ops(qau_pkg::OP_INV, C_MIN, C_MAX, C_MIN, C_MAX, 0, 0, 0, 0);
        send_ops(qau_pkg::OP_INV, ONE, -ONE, 3*ONE, 7, 0, 0, 0, 0);
        send_ops(qau_pkg::OP_DOT, ONE, 2*ONE, 3*ONE, 4*ONE, ONE, -ONE, ONE, -3);
        send_ops(qau_pkg::OP_DOT, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        send_ops(qau_pkg::OP_DOT, -1, 0, 0, 0, 1, 0, 0, 0);
        wait_drained();
    endtask

    task automatic test_random(input int n);
        repeat (n) send_quat(rand_quat());
    endtask

    // receiver holds off while the sender keeps offering, pipeline must fill and stall
    task automatic test_backpressure();
        rx_hold_cycles = 300;
        repeat (80) send_quat(rand_quat());
        wait_drained();
    endtask

    task automatic test_unthrottled(input int n);
        idling_on = 0;
        repeat (n) send_quat(rand_quat());
    endtask

    initial begin
        i_rst_n = 0;
        req_if.valid = 0;
        req_if.req_type = qau_pkg::OP_SUM;
        {req_if.a_w, req_if.a_x, req_if.a_y, req_if.a_z} = '0;
        {req_if.b_w, req_if.b_x, req_if.b_y, req_if.b_z} = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        test_directed();
        test_random(400);
        test_backpressure();
        test_random(300);
        test_unthrottled(150);

        req_if.valid = 0;
        wait (pending_results.size() == 0);
        repeat (80) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/qau_pkg.sv
hdl/qau_if.sv
hdl/quaternion_arithmetic_unit_core.sv
hdl/qau_checker.sv
tb/testbench.sv
